### rtl/assert_macros.svh
// Assertion macros for the register coloring block.
// Used by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define IGRC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("igrc assertion failed");
`define IGRC_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("igrc forbidden condition");
`else
`define IGRC_ASSERT(lbl, clk, rst_n, prop)
`define IGRC_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### rtl/igrc_pkg.sv
// Shared types, constants and helpers for the register coloring block.
// No dependencies.
package igrc_pkg;

	localparam int MAX_RANGES_DEF = 64;
	localparam int INDEX_BITS_DEF = 16;
	localparam int NODE_W = 6;
	localparam int REG_W = 4;
	localparam int CNT_W = 5;
	localparam int PRE_W = 5;
	localparam int CFG_IDX_W = 2;
	localparam logic [CNT_W-1:0] REG_COUNT_RESET = 5'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GENERAL = 2'd0,
		CFG_FLOAT   = 2'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_SPILL = 2'd1,
		STAT_NOREG = 2'd2
	} stat_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LOAD_SCAN,
		ST_LOAD_FIN,
		ST_ALLOC,
		ST_SCAN,
		ST_REM_RD,
		ST_REM,
		ST_DEC,
		ST_POP,
		ST_POP_V,
		ST_POP_INFO,
		ST_CSCAN,
		ST_ASSIGN,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_OUT_WAIT
	} state_t;

	function automatic logic [REG_W-1:0] usable_of(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] t;
		begin
			t = c - 5'd2;
			if (c < 5'd3) return 4'd1;
			else if (c > 5'd16) return 4'd14;
			else return t[REG_W-1:0];
		end
	endfunction

endpackage

### rtl/igrc_if.sv
// Channel interfaces of the register coloring block: ranges, results, config.
// Depends on igrc_pkg.
interface igrc_range_if #(parameter int IDX_W = igrc_pkg::INDEX_BITS_DEF);
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] range_start;
	logic [IDX_W-1:0] range_end;
	logic             is_float;
	logic             is_param;
	logic             last_range;
	modport source(output valid, range_start, range_end, is_float, is_param, last_range,
		input ready);
	modport sink(input valid, range_start, range_end, is_float, is_param, last_range,
		output ready);
endinterface

interface igrc_result_if;
	logic                          valid;
	logic                          ready;
	logic [igrc_pkg::NODE_W-1:0]   node_index;
	logic [igrc_pkg::REG_W-1:0]    reg_index;
	logic                          float_class;
	logic [1:0]                    status;
	logic                          last_result;
	modport source(output valid, node_index, reg_index, float_class, status, last_result,
		input ready);
	modport sink(input valid, node_index, reg_index, float_class, status, last_result,
		output ready);
endinterface

interface igrc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [igrc_pkg::CFG_IDX_W-1:0] index;
	logic [igrc_pkg::CNT_W-1:0]     data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### rtl/interval_graph_register_coloring.sv
// Interval-graph register allocator: load, simplify/spill, select, report.
// Depends on igrc_pkg, igrc_if.sv and assert_macros.svh.
//
// Usage: ranges (sink) takes one live range per request. Each request is
// compared against every range already held before the next is taken;
// ready is high only while the block is idle. The request with last_range
// set starts allocation. Simplify needs one pass over the degree memory
// plus one pass to decrement neighbor degrees per removed node; select
// needs one pass over the color memory per popped node. Results come out
// on results (source) in load order, one per stored range, the final one
// flagged last_result; each is held until the receiver takes it.
// A stalled receiver holds the result register and the whole block.
// cfg (sink) is always ready; write it only while idle.
// Reset clears control state and sets both register counts to 16; the
// range memories need no clearing pass.
`include "assert_macros.svh"

module interval_graph_register_coloring #(
	parameter int MAX_RANGES = igrc_pkg::MAX_RANGES_DEF,
	parameter int INDEX_BITS = igrc_pkg::INDEX_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	igrc_range_if.sink    ranges,
	igrc_result_if.source results,
	igrc_cfg_if.sink      cfg
);

	localparam int IW = $clog2(MAX_RANGES);
	localparam int CW = IW + 1;
	localparam int DW = IW;
	localparam int RW = igrc_pkg::REG_W;

	igrc_pkg::state_t state_q, state_d;

	logic [INDEX_BITS-1:0] start_mem [MAX_RANGES];
	logic [INDEX_BITS-1:0] end_mem [MAX_RANGES];
	logic                  cls_mem [MAX_RANGES];
	logic [igrc_pkg::PRE_W-1:0] pre_mem [MAX_RANGES];
	logic [MAX_RANGES-1:0] adj_mem [MAX_RANGES];
	logic [DW-1:0]         deg_mem [MAX_RANGES];
	logic [MAX_RANGES-1:0] psh_mem [MAX_RANGES];
	logic [IW-1:0]         stk_mem [MAX_RANGES];
	logic [RW-1:0]         col_mem [MAX_RANGES];
	logic [1:0]            stat_mem [MAX_RANGES];

	logic [INDEX_BITS-1:0] start_rd, end_rd;
	logic                  cls_rd;
	logic [igrc_pkg::PRE_W-1:0] pre_rd;
	logic [MAX_RANGES-1:0] adj_rd, psh_rd;
	logic [DW-1:0]         deg_rd;
	logic [IW-1:0]         stk_rd;
	logic [RW-1:0]         col_rd;
	logic [1:0]            stat_rd;

	logic [igrc_pkg::CNT_W-1:0] gen_cnt_q, flt_cnt_q;
	logic [CW-1:0] count_q, n_q, cnt_q, rem_q, depth_q, out_k_q;
	logic [IW-1:0] i_q, a_s1, pick_q, best_q, ch_q, v_q;
	logic          v_s1, last_q, pick_f_q, best_f_q, push_q, cls_q;
	logic [INDEX_BITS-1:0] s_q, e_q;
	logic [MAX_RANGES-1:0] row_q, alive_q, placed_q;
	logic [DW-1:0] dcount_q, best_deg_q;
	logic [3:0]    gp_q, fp_q;
	logic [igrc_pkg::PRE_W-1:0] pre_q;
	logic [15:0]   used_q;
	logic [RW-1:0] ug_q, uf_q;

	logic          ov_q, olast_q, ocls_q;
	logic [igrc_pkg::NODE_W-1:0] onode_q;
	logic [RW-1:0] oreg_q;
	logic [1:0]    ostat_q;

	logic          in_acc, out_acc, issue, scanning, pass_done;
	logic [CW-1:0] lim, rev;
	logic [IW-1:0] rd_addr, chosen;
	logic [CW-1:0] rem_inc, out_inc;

	// Assign step
	logic [RW-1:0] lim_r, new_col;
	logic [1:0]    new_stat;
	logic          found;

	assign in_acc  = ranges.valid && ranges.ready;
	assign out_acc = results.valid && results.ready;
	assign cfg.ready = 1'b1;
	assign ranges.ready = (state_q == igrc_pkg::ST_IDLE);

	assign results.valid       = ov_q;
	assign results.node_index  = onode_q;
	assign results.reg_index   = oreg_q;
	assign results.float_class = ocls_q;
	assign results.status      = ostat_q;
	assign results.last_result = olast_q;

	assign chosen  = pick_f_q ? pick_q : best_q;
	assign rev     = n_q - cnt_q - CW'(1);
	assign rem_inc = rem_q + CW'(1);
	assign out_inc = out_k_q + CW'(1);

	always_comb begin
		scanning = (state_q == igrc_pkg::ST_LOAD_SCAN) || (state_q == igrc_pkg::ST_SCAN) ||
			(state_q == igrc_pkg::ST_DEC) || (state_q == igrc_pkg::ST_CSCAN);
		lim = (state_q == igrc_pkg::ST_LOAD_SCAN) ? CW'(i_q) : n_q;
		issue = scanning && (cnt_q < lim);
		pass_done = scanning && !issue && !v_s1;
		unique case (state_q)
			igrc_pkg::ST_SCAN:     rd_addr = rev[IW-1:0];
			igrc_pkg::ST_REM_RD:   rd_addr = chosen;
			igrc_pkg::ST_POP_V:    rd_addr = stk_rd;
			igrc_pkg::ST_OUT_RD:   rd_addr = out_k_q[IW-1:0];
			default:               rd_addr = cnt_q[IW-1:0];
		endcase
	end

	always_comb begin
		lim_r = cls_q ? uf_q : ug_q;
		new_col = '0;
		new_stat = igrc_pkg::STAT_NOREG;
		found = 1'b0;
		if (pre_q[4] && (pre_q[3:0] < lim_r)) begin
			new_col = pre_q[3:0];
			new_stat = igrc_pkg::STAT_OK;
		end else begin
			for (int r = 0; r < 16; r++) begin
				if (!found && (RW'(r) < lim_r) && !used_q[r]) begin
					found = 1'b1;
					new_col = RW'(r);
					new_stat = igrc_pkg::STAT_OK;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= igrc_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			igrc_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (count_q < CW'(MAX_RANGES)) state_d = igrc_pkg::ST_LOAD_SCAN;
					else if (ranges.last_range) state_d = igrc_pkg::ST_ALLOC;
				end
			end
			igrc_pkg::ST_LOAD_SCAN: if (pass_done) state_d = igrc_pkg::ST_LOAD_FIN;
			igrc_pkg::ST_LOAD_FIN:
				state_d = last_q ? igrc_pkg::ST_ALLOC : igrc_pkg::ST_IDLE;
			igrc_pkg::ST_ALLOC:
				state_d = (count_q == '0) ? igrc_pkg::ST_IDLE : igrc_pkg::ST_SCAN;
			igrc_pkg::ST_SCAN: if (pass_done) state_d = igrc_pkg::ST_REM_RD;
			igrc_pkg::ST_REM_RD: state_d = igrc_pkg::ST_REM;
			igrc_pkg::ST_REM: state_d = igrc_pkg::ST_DEC;
			igrc_pkg::ST_DEC: begin
				if (pass_done)
					state_d = (rem_inc == n_q) ? igrc_pkg::ST_POP : igrc_pkg::ST_SCAN;
			end
			igrc_pkg::ST_POP:
				state_d = (depth_q == '0) ? igrc_pkg::ST_OUT_RD : igrc_pkg::ST_POP_V;
			igrc_pkg::ST_POP_V: state_d = igrc_pkg::ST_POP_INFO;
			igrc_pkg::ST_POP_INFO: state_d = igrc_pkg::ST_CSCAN;
			igrc_pkg::ST_CSCAN: if (pass_done) state_d = igrc_pkg::ST_ASSIGN;
			igrc_pkg::ST_ASSIGN: state_d = igrc_pkg::ST_POP;
			igrc_pkg::ST_OUT_RD: state_d = igrc_pkg::ST_OUT_LD;
			igrc_pkg::ST_OUT_LD: state_d = igrc_pkg::ST_OUT_WAIT;
			igrc_pkg::ST_OUT_WAIT: begin
				if (out_acc)
					state_d = (out_inc == n_q) ? igrc_pkg::ST_IDLE : igrc_pkg::ST_OUT_RD;
			end
			default: state_d = igrc_pkg::ST_IDLE;
		endcase
	end

	// Memory reads
	always_ff @(posedge clk) begin
		start_rd <= start_mem[rd_addr];
		end_rd   <= end_mem[rd_addr];
		cls_rd   <= cls_mem[rd_addr];
		pre_rd   <= pre_mem[rd_addr];
		adj_rd   <= adj_mem[rd_addr];
		deg_rd   <= deg_mem[rd_addr];
		psh_rd   <= psh_mem[rd_addr];
		col_rd   <= col_mem[rd_addr];
		stat_rd  <= stat_mem[rd_addr];
		stk_rd   <= stk_mem[IW'(depth_q - CW'(1))];
	end

	// Memory writes
	always_ff @(posedge clk) begin
		if (state_q == igrc_pkg::ST_IDLE && in_acc && count_q < CW'(MAX_RANGES)) begin
			start_mem[count_q[IW-1:0]] <= ranges.range_start;
			end_mem[count_q[IW-1:0]]   <= ranges.range_end;
			cls_mem[count_q[IW-1:0]]   <= ranges.is_float;
			if (ranges.is_param)
				pre_mem[count_q[IW-1:0]] <= {1'b1, ranges.is_float ? fp_q : gp_q};
			else
				pre_mem[count_q[IW-1:0]] <= '0;
		end
		if (state_q == igrc_pkg::ST_LOAD_SCAN && v_s1 && s_q <= end_rd && start_rd <= e_q)
			begin
			adj_mem[a_s1] <= adj_rd | (MAX_RANGES'(1) << i_q);
			deg_mem[a_s1] <= deg_rd + DW'(1);
		end
		if (state_q == igrc_pkg::ST_LOAD_FIN) begin
			adj_mem[i_q] <= row_q;
			deg_mem[i_q] <= dcount_q;
		end
		if (state_q == igrc_pkg::ST_DEC && v_s1 && row_q[a_s1])
			deg_mem[a_s1] <= deg_rd - DW'(1);
		if (state_q == igrc_pkg::ST_REM) begin
			if (push_q) begin
				psh_mem[ch_q] <= adj_rd & alive_q;
				stk_mem[depth_q[IW-1:0]] <= ch_q;
			end else begin
				stat_mem[ch_q] <= igrc_pkg::STAT_SPILL;
			end
		end
		if (state_q == igrc_pkg::ST_ASSIGN) begin
			col_mem[v_q]  <= new_col;
			stat_mem[v_q] <= new_stat;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_cnt_q <= igrc_pkg::REG_COUNT_RESET;
			flt_cnt_q <= igrc_pkg::REG_COUNT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				igrc_pkg::CFG_GENERAL: gen_cnt_q <= cfg.data;
				igrc_pkg::CFG_FLOAT:   flt_cnt_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			gp_q <= '0;
			fp_q <= '0;
			alive_q <= '0;
			placed_q <= '0;
			cnt_q <= '0;
			v_s1 <= 1'b0;
			rem_q <= '0;
			depth_q <= '0;
			out_k_q <= '0;
			n_q <= '0;
			last_q <= 1'b0;
			pick_f_q <= 1'b0;
			best_f_q <= 1'b0;
			push_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			if (state_q != state_d) cnt_q <= '0;
			else if (issue) cnt_q <= cnt_q + CW'(1);
			unique case (state_q)
				igrc_pkg::ST_IDLE: begin
					if (in_acc) begin
						last_q <= ranges.last_range;
						if (count_q < CW'(MAX_RANGES) && ranges.is_param) begin
							if (ranges.is_float && fp_q != 4'd15) fp_q <= fp_q + 4'd1;
							if (!ranges.is_float && gp_q != 4'd15) gp_q <= gp_q + 4'd1;
						end
					end
				end
				igrc_pkg::ST_LOAD_FIN: count_q <= count_q + CW'(1);
				igrc_pkg::ST_ALLOC: begin
					n_q <= count_q;
					rem_q <= '0;
					depth_q <= '0;
					for (int k = 0; k < MAX_RANGES; k++)
						alive_q[k] <= (CW'(k) < count_q);
					if (count_q == '0) begin
						gp_q <= '0;
						fp_q <= '0;
					end
				end
				igrc_pkg::ST_SCAN: begin
					if (v_s1 && alive_q[a_s1]) begin
						if (!pick_f_q && ((DW+4)'(deg_rd) < (DW+4)'(ug_q))) begin
							pick_f_q <= 1'b1;
						end
						if (!best_f_q || deg_rd > best_deg_q) best_f_q <= 1'b1;
					end
				end
				igrc_pkg::ST_REM_RD: push_q <= pick_f_q;
				igrc_pkg::ST_REM: begin
					alive_q[ch_q] <= 1'b0;
					if (push_q) depth_q <= depth_q + CW'(1);
				end
				igrc_pkg::ST_DEC: if (pass_done) rem_q <= rem_inc;
				igrc_pkg::ST_POP: begin
					if (depth_q != '0) depth_q <= depth_q - CW'(1);
					out_k_q <= '0;
				end
				igrc_pkg::ST_ASSIGN: placed_q[v_q] <= 1'b1;
				igrc_pkg::ST_OUT_LD: ov_q <= 1'b1;
				igrc_pkg::ST_OUT_WAIT: begin
					if (out_acc) begin
						ov_q <= 1'b0;
						out_k_q <= out_inc;
						if (out_inc == n_q) begin
							count_q <= '0;
							gp_q <= '0;
							fp_q <= '0;
							alive_q <= '0;
						end
					end
				end
				default: ;
			endcase
			if (state_d == igrc_pkg::ST_SCAN && state_q != igrc_pkg::ST_SCAN) begin
				pick_f_q <= 1'b0;
				best_f_q <= 1'b0;
			end
			if (state_q == igrc_pkg::ST_DEC && state_d == igrc_pkg::ST_POP)
				placed_q <= '0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		a_s1 <= rd_addr;
		unique case (state_q)
			igrc_pkg::ST_IDLE: begin
				i_q <= count_q[IW-1:0];
				s_q <= ranges.range_start;
				e_q <= ranges.range_end;
				row_q <= '0;
				dcount_q <= '0;
			end
			igrc_pkg::ST_LOAD_SCAN: begin
				if (v_s1 && s_q <= end_rd && start_rd <= e_q) begin
					row_q[a_s1] <= 1'b1;
					dcount_q <= dcount_q + DW'(1);
				end
			end
			igrc_pkg::ST_ALLOC: begin
				ug_q <= igrc_pkg::usable_of(gen_cnt_q);
				uf_q <= igrc_pkg::usable_of(flt_cnt_q);
			end
			igrc_pkg::ST_SCAN: begin
				if (v_s1 && alive_q[a_s1]) begin
					if (!pick_f_q && ((DW+4)'(deg_rd) < (DW+4)'(ug_q))) pick_q <= a_s1;
					if (!best_f_q || deg_rd > best_deg_q) begin
						best_q <= a_s1;
						best_deg_q <= deg_rd;
					end
				end
			end
			igrc_pkg::ST_REM_RD: ch_q <= chosen;
			igrc_pkg::ST_REM: row_q <= adj_rd;
			igrc_pkg::ST_POP_V: v_q <= stk_rd;
			igrc_pkg::ST_POP_INFO: begin
				cls_q <= cls_rd;
				pre_q <= pre_rd;
				row_q <= psh_rd;
				used_q <= '0;
			end
			igrc_pkg::ST_CSCAN: begin
				if (v_s1 && row_q[a_s1] && placed_q[a_s1] &&
					stat_rd == igrc_pkg::STAT_OK && cls_rd == cls_q)
					used_q[col_rd] <= 1'b1;
			end
			igrc_pkg::ST_OUT_LD: begin
				onode_q <= igrc_pkg::NODE_W'(out_k_q);
				oreg_q  <= (stat_rd == igrc_pkg::STAT_OK) ? col_rd : '0;
				ocls_q  <= cls_rd;
				ostat_q <= stat_rd;
				olast_q <= (out_inc == n_q);
			end
			default: ;
		endcase
	end

	`IGRC_NEVER(a_ready_while_out, clk, arst_n, ranges.ready && results.valid)
	`IGRC_NEVER(a_depth_bound, clk, arst_n, depth_q > n_q)
	`IGRC_ASSERT(a_last_to_idle, clk, arst_n, (out_acc && results.last_result) |=> (state_q == igrc_pkg::ST_IDLE && count_q == '0))

endmodule

### dv/tb.sv
// Testbench for interval_graph_register_coloring: loads live-range sets, predicts
// the simplify/spill/select coloring and checks every reported node in order.
// Depends on igrc_pkg and igrc_if.sv.
`timescale 1ns / 100ps

module tb;

	localparam int NMAX = 64;

	typedef struct packed {
		logic [15:0] rs;
		logic [15:0] re;
		logic        fl;
		logic        prm;
		logic        last;
	} range_t;

	typedef struct packed {
		logic [5:0]       node;
		logic [3:0]       rg;
		logic             fcls;
		igrc_pkg::stat_t  st;
		logic             lastr;
	} alloc_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors = 0;

	igrc_range_if  rng_if ();
	igrc_result_if res_if ();
	igrc_cfg_if    cfg_if ();

	interval_graph_register_coloring dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.ranges  (rng_if.sink),
		.results (res_if.source),
		.cfg     (cfg_if.sink)
	);

	always #4 clk = ~clk;

	initial begin
		#50ms;
		$display("Simulation FAILED");
		$finish;
	end

	// predictor state
	logic [15:0] p_start [NMAX];
	logic [15:0] p_end [NMAX];
	logic        p_fl [NMAX];
	logic [4:0]  p_pre [NMAX];
	logic [NMAX-1:0] p_adj [NMAX];
	int   p_n = 0, p_gp = 0, p_fp = 0;
	logic [4:0] p_gcnt = 5'd16, p_fcnt = 5'd16;
	alloc_t expected_allocs [$];
	bit   exact_check [$];
	alloc_t exact_vals [$];

	function automatic int usable(logic [4:0] c);
		if (c < 3) return 1;
		if (c > 16) return 14;
		return int'(c) - 2;
	endfunction

	task automatic predict_range(range_t r);
		logic [NMAX-1:0] alive, placed;
		logic [NMAX-1:0] pushed [NMAX];
		int stack [$];
		int stt [NMAX];
		int col [NMAX];
		int ug, uf, pick, best, bdeg, d, v, lim, i;
		bit done, taken;
		alloc_t a;
		if (p_n < NMAX) begin
			i = p_n;
			p_start[i] = r.rs;
			p_end[i] = r.re;
			p_fl[i] = r.fl;
			p_pre[i] = '0;
			if (r.prm) begin
				if (r.fl) begin
					p_pre[i] = 5'(16 + p_fp);
					if (p_fp < 15) p_fp++;
				end else begin
					p_pre[i] = 5'(16 + p_gp);
					if (p_gp < 15) p_gp++;
				end
			end
			p_adj[i] = '0;
			for (int j = 0; j < i; j++)
				if (r.rs <= p_end[j] && p_start[j] <= r.re) begin
					p_adj[i][j] = 1'b1;
					p_adj[j][i] = 1'b1;
				end
			p_n++;
		end
		if (!r.last) return;
		ug = usable(p_gcnt);
		uf = usable(p_fcnt);
		alive = '0;
		for (int k = 0; k < p_n; k++) begin
			alive[k] = 1'b1;
			stt[k] = 0;
			col[k] = 0;
		end
		for (int k = 0; k < p_n; k++) begin
			pick = -1;
			best = -1;
			bdeg = 0;
			for (v = p_n - 1; v >= 0; v--) begin
				if (!alive[v]) continue;
				d = $countones(p_adj[v] & alive);
				if (pick < 0 && d < ug) pick = v;
				if (best < 0 || d > bdeg) begin
					best = v;
					bdeg = d;
				end
			end
			if (pick >= 0) begin
				pushed[pick] = p_adj[pick] & alive;
				stack.insert(stack.size(), pick);
				alive[pick] = 1'b0;
			end else if (best >= 0) begin
				stt[best] = 1;
				alive[best] = 1'b0;
			end
		end
		placed = '0;
		while (stack.size() > 0) begin
			v = stack[stack.size() - 1];
			stack.delete(stack.size() - 1);
			lim = p_fl[v] ? uf : ug;
			if (p_pre[v][4] && int'(p_pre[v][3:0]) < lim) begin
				col[v] = p_pre[v][3:0];
				stt[v] = 0;
			end else begin
				done = 0;
				for (int rg = 0; rg < lim && !done; rg++) begin
					taken = 0;
					for (int j = 0; j < p_n; j++)
						if (pushed[v][j] && placed[j] && stt[j] == 0 &&
							p_fl[j] == p_fl[v] && col[j] == rg)
							taken = 1;
					if (!taken) begin
						col[v] = rg;
						stt[v] = 0;
						done = 1;
					end
				end
				if (!done) stt[v] = 2;
			end
			placed[v] = 1'b1;
		end
		for (int k = 0; k < p_n; k++) begin
			a.node = 6'(k);
			a.rg = stt[k] == 0 ? 4'(col[k]) : 4'd0;
			a.fcls = p_fl[k];
			a.st = igrc_pkg::stat_t'(stt[k]);
			a.lastr = (k + 1 == p_n);
			expected_allocs.insert(expected_allocs.size(), a);
		end
		p_n = 0;
		p_gp = 0;
		p_fp = 0;
	endtask

	// result checker
	always @(posedge clk) begin
		alloc_t e;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_allocs.size() == 0) begin
				$error("unexpected result node %0d", res_if.node_index);
				errors++;
			end else begin
				e = expected_allocs.pop_front();
				if (exact_check.size() > 0 && exact_check[0]) e = exact_vals[0];
				if (exact_check.size() > 0 && res_if.last_result) begin
					void'(exact_check.pop_front());
					void'(exact_vals.pop_front());
				end
				if (res_if.node_index !== e.node) begin
					$error("node_index exp %0d got %0d", e.node, res_if.node_index);
					errors++;
				end
				if (res_if.reg_index !== e.rg) begin
					$error("reg_index exp %0d got %0d", e.rg, res_if.reg_index);
					errors++;
				end
				if (res_if.float_class !== e.fcls) begin
					$error("float_class exp %0d got %0d", e.fcls, res_if.float_class);
					errors++;
				end
				if (res_if.status !== e.st) begin
					$error("status exp %0d got %0d", e.st, res_if.status);
					errors++;
				end
				if (res_if.last_result !== e.lastr) begin
					$error("last_result exp %0d got %0d", e.lastr, res_if.last_result);
					errors++;
				end
			end
		end
	end

	// random receiver stalls
	initial begin
		int gap;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 3) == 0) begin
				res_if.ready <= 1'b1;
				repeat ($urandom_range(10, 60)) @(posedge clk);
			end else begin
				gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 2);
				if (gap > 0) begin
					res_if.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				res_if.ready <= 1'b1;
			end
		end
	end

	task automatic send_range(range_t r, bit exact, alloc_t ev);
		int gap;
		if ($urandom_range(0, 9) == 0) gap = $urandom_range(5, 30);
		else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
		else gap = 0;
		if (gap > 0) begin
			rng_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rng_if.valid <= 1'b1;
		{rng_if.range_start, rng_if.range_end, rng_if.is_float, rng_if.is_param,
			rng_if.last_range} <= r;
		@(posedge clk);
		while (!rng_if.ready) @(posedge clk);
		predict_range(r);
		if (r.last) begin
			exact_check.insert(exact_check.size(), exact);
			exact_vals.insert(exact_vals.size(), ev);
		end
	endtask

	task automatic drain_results();
		rng_if.valid <= 1'b0;
		while (expected_allocs.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(igrc_pkg::cfg_idx_t idx, logic [4:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
		if (idx == igrc_pkg::CFG_GENERAL) p_gcnt = val;
		else p_fcnt = val;
		@(posedge clk);
	endtask

	task automatic random_set(int len, int span);
		range_t r;
		alloc_t none;
		none = '0;
		for (int k = 0; k < len; k++) begin
			r.rs = 16'($urandom_range(0, span));
			r.re = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, span))
				: 16'(r.rs + $urandom_range(0, span / 4));
			if ($urandom_range(0, 19) == 0) begin
				r.rs = 16'($urandom);
				r.re = 16'($urandom);
			end
			r.fl = 1'($urandom_range(0, 1));
			r.prm = ($urandom_range(0, 3) == 0);
			r.last = (k == len - 1);
			send_range(r, 0, none);
		end
	endtask

	typedef struct {
		range_t r;
		bit     exact;
		alloc_t ev;
	} stim_row_t;

	initial begin
		stim_row_t dir [$];
		int sent;
		int set_len;
		rng_if.valid <= 1'b0;
		rng_if.range_start <= '0;
		rng_if.range_end <= '0;
		rng_if.is_float <= 1'b0;
		rng_if.is_param <= 1'b0;
		rng_if.last_range <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= igrc_pkg::CFG_GENERAL;
		cfg_if.data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single range after reset, extremes, params, start after end
		dir.insert(dir.size(), '{'{16'd0, 16'd0, 1'b0, 1'b0, 1'b1}, 1,
			'{6'd0, 4'd0, 1'b0, igrc_pkg::STAT_OK, 1'b1}});
		dir.insert(dir.size(), '{'{16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b1}, 1,
			'{6'd0, 4'd0, 1'b1, igrc_pkg::STAT_OK, 1'b1}});
		dir.insert(dir.size(), '{'{16'd0, 16'hFFFF, 1'b0, 1'b1, 1'b0}, 0, '0});
		dir.insert(dir.size(), '{'{16'd5, 16'd10, 1'b0, 1'b1, 1'b0}, 0, '0});
		dir.insert(dir.size(), '{'{16'd8, 16'd3, 1'b1, 1'b1, 1'b0}, 0, '0});
		dir.insert(dir.size(), '{'{16'd3, 16'd8, 1'b1, 1'b0, 1'b0}, 0, '0});
		dir.insert(dir.size(), '{'{16'hAAAA, 16'h5555, 1'b0, 1'b0, 1'b0}, 0, '0});
		dir.insert(dir.size(), '{'{16'h5555, 16'hAAAA, 1'b1, 1'b0, 1'b1}, 0, '0});
		foreach (dir[k]) send_range(dir[k].r, dir[k].exact, dir[k].ev);
		sent = dir.size();
		drain_results();

		// tiny register files, clique forces spills, too many params
		write_reg(igrc_pkg::CFG_GENERAL, 5'd0);
		write_reg(igrc_pkg::CFG_FLOAT, 5'd3);
		for (int k = 0; k < 18; k++) begin
			send_range('{16'd0, 16'd100, 1'(k % 2), 1'(k < 17), 1'(k == 17)}, 0, '0);
			sent++;
		end
		drain_results();

		write_reg(igrc_pkg::CFG_GENERAL, 5'd31);
		write_reg(igrc_pkg::CFG_FLOAT, 5'd16);
		while (sent < 110) begin
			set_len = $urandom_range(1, 12);
			random_set(set_len, 200);
			sent = sent + set_len;
		end
		drain_results();

		// full store: 64 ranges plus ignored ones, last on an ignored item
		write_reg(igrc_pkg::CFG_GENERAL, 5'd5);
		write_reg(igrc_pkg::CFG_FLOAT, 5'd4);
		for (int k = 0; k < 67; k++)
			send_range('{16'($urandom_range(0, 300)), 16'($urandom_range(300, 600)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'(k == 66)}, 0, '0);
		drain_results();

		write_reg(igrc_pkg::CFG_GENERAL, 5'd16);
		write_reg(igrc_pkg::CFG_FLOAT, 5'd6);
		for (int n = 0; n < 130; ) begin
			int len;
			len = $urandom_range(1, 10);
			random_set(len, 60);
			n += len;
		end
		drain_results();

		while (expected_allocs.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule

### interval_graph_register_coloring.f
+incdir+rtl
rtl/igrc_pkg.sv
rtl/igrc_if.sv
rtl/interval_graph_register_coloring.sv
dv/tb.sv
